[sv/loog_pkg.sv]
// package for the log-odds occupancy grid
// holds the state, operation and register codes and the controller interface structs
// no dependencies
package loog_pkg;

  // fixed field widths
  localparam int FUNC_W     = 2;
  localparam int CX_W       = 7;
  localparam int CY_W       = 7;
  localparam int CZ_W       = 2;
  localparam int VALUE_W    = 15;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;
  localparam int MISS_W     = 13;
  localparam int HIT_W      = 13;
  localparam int CLO_W      = 15;
  localparam int CHI_W      = 14;

  // register reset values
  localparam logic signed [MISS_W-1:0] MISS_RESET = -13'sd104;
  localparam logic        [HIT_W-1:0]  HIT_RESET  = 13'd217;
  localparam logic signed [CLO_W-1:0]  CLO_RESET  = -15'sd510;
  localparam logic        [CHI_W-1:0]  CHI_RESET  = 14'd890;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MISS_STEP  = 2'd0,
    CFG_HIT_STEP   = 2'd1,
    CFG_CLAMP_LOW  = 2'd2,
    CFG_CLAMP_HIGH = 2'd3
  } cfg_index_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_FREE     = 2'd0,
    FUNC_OCCUPIED = 2'd1,
    FUNC_UNKNOWN  = 2'd2,
    FUNC_QUERY    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clear_write;
    logic accept;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_status_t;

endpackage

[sv/log_odds_occupancy_grid.sv]
// top level of the log-odds occupancy grid map update block
// instantiates loog_ctrl, loog_datapath and loog_ram; depends on loog_pkg
//
// A dense grid of signed Q8.8 log-odds cells held in one ram. After reset the
// block sweeps the whole ram to zero (unknown), one cell a cycle, over all
// 2**(X_BITS+Y_BITS+Z_BITS) cells (65536 at the defaults); req_ready stays low
// during the sweep while config writes are taken as usual. Each request is then
// read from the ram as it is taken (registered read port), then updated, written
// back and loaded into the response register once that register is free. A new
// request is taken in the cycle after the update, so back-to-back updates of one
// cell always see the value just written. The response register lets the block
// take the next request while the previous response still waits on rsp_ready.
module log_odds_occupancy_grid #(
  parameter int X_BITS    = 7,
  parameter int Y_BITS    = 7,
  parameter int Z_BITS    = 2,
  parameter int CELL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // config write port
  input  logic                                cfg_we,
  input  logic [loog_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [loog_pkg::CFG_DATA_W-1:0]     cfg_data,
  // request channel
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [loog_pkg::FUNC_W-1:0]         func,
  input  logic [loog_pkg::CX_W-1:0]           cell_x,
  input  logic [loog_pkg::CY_W-1:0]           cell_y,
  input  logic [loog_pkg::CZ_W-1:0]           cell_z,
  // response channel
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic                                changed,
  output logic                                is_free,
  output logic                                is_occupied,
  output logic                                is_unknown,
  output logic signed [loog_pkg::VALUE_W-1:0] cell_value
);

  import loog_pkg::*;

  localparam int ADDR_W = X_BITS + Y_BITS + Z_BITS;

  dp_cmd_t    cmd;
  dp_status_t status;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [CELL_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [CELL_BITS-1:0] ram_rdata;

  // sequencing: clear sweep, idle, read
  loog_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // registers, update arithmetic and response register
  loog_datapath #(
    .X_BITS    (X_BITS),
    .Y_BITS    (Y_BITS),
    .Z_BITS    (Z_BITS),
    .CELL_BITS (CELL_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .func        (func),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .cell_z      (cell_z),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .changed     (changed),
    .is_free     (is_free),
    .is_occupied (is_occupied),
    .is_unknown  (is_unknown),
    .cell_value  (cell_value)
  );

  // cell store, one cell per address
  loog_ram #(
    .WIDTH     (CELL_BITS),
    .ADDR_BITS (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

`ifndef NO_ASSERTIONS
  // the clear sweep always follows reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken during clear sweep");

  // one request in flight: ready drops right after a request is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request taken while another is in flight");

  // exactly one class flag per response
  a_one_class: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $onehot({is_free, is_occupied, is_unknown}))
    else $error("response class flags not one-hot");

  // class flags agree with the value
  a_class_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_unknown == (cell_value == 0)) && (is_free == cell_value[14]))
    else $error("response flags disagree with cell value");
`endif

endmodule

[sv/loog_ram.sv]
// generic single-write, single-read ram with registered read data
// depth is two to the power of the address width; no dependencies
module loog_ram #(
  parameter int WIDTH     = 16,
  parameter int ADDR_BITS = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/loog_ctrl.sv]
// controller for the log-odds occupancy grid: clear pass, read, commit
// depends on loog_pkg
module loog_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  loog_pkg::dp_status_t status,
  output loog_pkg::dp_cmd_t    cmd
);

  import loog_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_READ;
      end
      ST_READ: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    req_ready       = 1'b0;
    cmd.clear_write = 1'b0;
    cmd.accept      = 1'b0;
    cmd.commit      = 1'b0;
    case (state)
      ST_CLEAR: cmd.clear_write = 1'b1;
      ST_IDLE: begin
        req_ready  = 1'b1;
        cmd.accept = req_valid;
      end
      ST_READ: cmd.commit = status.out_free;
      default: ;
    endcase
  end

endmodule

[sv/loog_datapath.sv]
// datapath for the log-odds occupancy grid: config registers, request latch,
// cell update arithmetic, clear counter and response register; depends on loog_pkg
module loog_datapath #(
  parameter int X_BITS    = 7,
  parameter int Y_BITS    = 7,
  parameter int Z_BITS    = 2,
  parameter int CELL_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  loog_pkg::dp_cmd_t                      cmd,
  output loog_pkg::dp_status_t                   status,
  input  logic                                   cfg_we,
  input  logic [loog_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [loog_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [loog_pkg::FUNC_W-1:0]            func,
  input  logic [loog_pkg::CX_W-1:0]              cell_x,
  input  logic [loog_pkg::CY_W-1:0]              cell_y,
  input  logic [loog_pkg::CZ_W-1:0]              cell_z,
  output logic                                   ram_we,
  output logic [X_BITS+Y_BITS+Z_BITS-1:0]        ram_waddr,
  output logic [CELL_BITS-1:0]                   ram_wdata,
  output logic                                   ram_re,
  output logic [X_BITS+Y_BITS+Z_BITS-1:0]        ram_raddr,
  input  logic [CELL_BITS-1:0]                   ram_rdata,
  output logic                                   rsp_valid,
  input  logic                                   rsp_ready,
  output logic                                   changed,
  output logic                                   is_free,
  output logic                                   is_occupied,
  output logic                                   is_unknown,
  output logic signed [loog_pkg::VALUE_W-1:0]    cell_value
);

  import loog_pkg::*;

  localparam int ADDR_W = X_BITS + Y_BITS + Z_BITS;
  localparam int SUM_W  = ((CELL_BITS > 16) ? CELL_BITS : 16) + 2;
  localparam longint SAT_HI_L = (CELL_BITS > 15) ? 64'sd16383
                                                 : (longint'(1) <<< (CELL_BITS - 1)) - 1;
  localparam longint SAT_LO_L = -SAT_HI_L - 1;
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(SAT_HI_L);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(SAT_LO_L);

  logic signed [MISS_W-1:0] miss_step;
  logic        [HIT_W-1:0]  hit_step;
  logic signed [CLO_W-1:0]  clamp_low;
  logic        [CHI_W-1:0]  clamp_high;

  logic [FUNC_W-1:0] op;
  logic [ADDR_W-1:0] op_addr;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] req_addr;

  logic [X_BITS-1:0] ax;
  logic [Y_BITS-1:0] ay;
  logic [Z_BITS-1:0] az;

  logic signed [SUM_W-1:0] old_v;
  logic signed [SUM_W-1:0] sum_v;
  logic signed [SUM_W-1:0] lim_v;
  logic signed [SUM_W-1:0] nv;
  logic                    chg;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      miss_step  <= MISS_RESET;
      hit_step   <= HIT_RESET;
      clamp_low  <= CLO_RESET;
      clamp_high <= CHI_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MISS_STEP:  miss_step  <= cfg_data[MISS_W-1:0];
        CFG_HIT_STEP:   hit_step   <= cfg_data[HIT_W-1:0];
        CFG_CLAMP_LOW:  clamp_low  <= cfg_data[CLO_W-1:0];
        CFG_CLAMP_HIGH: clamp_high <= cfg_data[CHI_W-1:0];
        default: ;
      endcase
    end
  end

  // coordinate bits above the map size are dropped
  assign ax       = X_BITS'(cell_x);
  assign ay       = Y_BITS'(cell_y);
  assign az       = Z_BITS'(cell_z);
  assign req_addr = {az, ay, ax};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op      <= func;
      op_addr <= req_addr;
    end
  end

  // clear sweep address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_write) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // cell update
  assign old_v = {{(SUM_W-CELL_BITS){ram_rdata[CELL_BITS-1]}}, ram_rdata};

  always_comb begin
    sum_v = old_v;
    lim_v = old_v;
    nv    = old_v;
    chg   = 1'b0;
    case (op)
      FUNC_FREE: begin
        sum_v = old_v + $signed({{(SUM_W-MISS_W){miss_step[MISS_W-1]}}, miss_step});
        lim_v = sum_v;
        if (sum_v < $signed({{(SUM_W-CLO_W){clamp_low[CLO_W-1]}}, clamp_low})) begin
          lim_v = $signed({{(SUM_W-CLO_W){clamp_low[CLO_W-1]}}, clamp_low});
        end
        nv = lim_v;
        if (lim_v > SAT_HI) nv = SAT_HI;
        else if (lim_v < SAT_LO) nv = SAT_LO;
        chg = !old_v[SUM_W-1] && nv[SUM_W-1];
      end
      FUNC_OCCUPIED: begin
        sum_v = old_v + $signed({{(SUM_W-HIT_W){1'b0}}, hit_step});
        lim_v = sum_v;
        if (sum_v > $signed({{(SUM_W-CHI_W){1'b0}}, clamp_high})) begin
          lim_v = $signed({{(SUM_W-CHI_W){1'b0}}, clamp_high});
        end
        nv = lim_v;
        if (lim_v > SAT_HI) nv = SAT_HI;
        else if (lim_v < SAT_LO) nv = SAT_LO;
        chg = !(old_v > 0) && (nv > 0);
      end
      FUNC_UNKNOWN: begin
        nv  = '0;
        chg = (old_v != 0);
      end
      default: ;
    endcase
  end

  // ram access
  assign ram_re    = cmd.accept;
  assign ram_raddr = req_addr;
  assign ram_we    = cmd.clear_write || cmd.commit;
  assign ram_waddr = cmd.clear_write ? clr_addr : op_addr;
  assign ram_wdata = cmd.clear_write ? '0 : nv[CELL_BITS-1:0];

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      changed     <= chg;
      is_free     <= nv < 0;
      is_occupied <= nv > 0;
      is_unknown  <= nv == 0;
      cell_value  <= nv[VALUE_W-1:0];
    end
  end

  assign status.clear_last = &clr_addr;
  assign status.out_free   = !rsp_valid || rsp_ready;

endmodule
